// ===== hdl/phcs_pkg.sv =====
// Shared constants and functions for the packet header clock search block.
// Holds the field widths, the whitening sequence and the HEC register function.
// No dependencies.
package phcs_pkg;

    localparam int CODED_W = 54;
    localparam int UAP_W   = 8;
    localparam int HDR_W   = 18;
    localparam int DATA_W  = 10;
    localparam int HEC_W   = 8;
    localparam int NUM_CLK = 64;
    localparam int CLK_W   = 6;
    localparam int CNT_W   = 7;
    localparam int WH_W    = 7;

    localparam logic [HEC_W-1:0] HEC_POLY = 8'hA7;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 96;

    // Whitening bits for one clock value; bit i is XORed into header bit i.
    // The register is x^7 + x^4 + 1, loaded with the clock and bit 6 set.
    function automatic logic [HDR_W-1:0] whiten_seq(input logic [CLK_W-1:0] clk_val);
        logic [WH_W-1:0]  w;
        logic             o;
        logic [HDR_W-1:0] s;
        w = {1'b1, clk_val};
        s = '0;
        for (int i = 0; i < HDR_W; i++) begin
            o    = w[WH_W-1];
            s[i] = o;
            w    = {w[WH_W-2:0], 1'b0} ^ {2'b00, o, 3'b000, o};
        end
        return s;
    endfunction

    // HEC register after shifting in the data bits, seeded with the UAP.
    function automatic logic [HEC_W-1:0] hec_calc(input logic [DATA_W-1:0] data,
                                                  input logic [UAP_W-1:0]  uap);
        logic [HEC_W-1:0] r;
        logic             fb;
        r = uap;
        for (int i = 0; i < DATA_W; i++) begin
            fb = r[HEC_W-1] ^ data[i];
            r  = {r[HEC_W-2:0], 1'b0};
            if (fb) begin
                r = r ^ HEC_POLY;
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/packet_header_clock_search_top.sv =====
// Top level of the packet header clock search: three-stage stream pipeline.
// Depends on phcs_pkg, phcs_fec_decode, phcs_clock_trial and phcs_popcount.
//
// Usage:
//   Input stream s_axis carries one request per received header: the 54 coded
//   symbols and a candidate UAP. Output stream m_axis carries one result per
//   request: the majority-decoded header, the FEC flag, the 64-bit mask of
//   clock values whose HEC matched and the number of matches.
//   An accepted request is registered in stage a, then stage b, then stage c,
//   whose valid flag drives m_axis_tvalid.
//   Throughput is one request per cycle while m_axis_tready stays high; the
//   stage holding the 64 parallel clock trials (dewhitening and HEC per clock)
//   sets that figure, and the match count is formed in the stage after it.
//   When the FEC check fails the mask and the count are zero.
//   Reset clears every stage valid flag; no result is pending afterwards.
//   When the receiver stalls, results stay in their stages and s_axis_tready
//   drops only once all three stages hold a result.
module packet_header_clock_search_top
    import phcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [53:0] coded_bits, [61:54] uap_guess, [63:62] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [17:0] raw_header, [18] fec_ok, [82:19] clock_match_mask,
    // [89:83] match_count, [95:90] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic               r_a_valid, r_b_valid, r_c_valid;
    logic               w_a_ready, w_b_ready, w_c_ready;
    logic [CODED_W-1:0] r_a_coded;
    logic [UAP_W-1:0]   r_a_uap;
    logic [HDR_W-1:0]   r_b_hdr, r_c_hdr;
    logic               r_b_ok, r_c_ok;
    logic [NUM_CLK-1:0] r_b_mask, r_c_mask;
    logic [CNT_W-1:0]   r_c_count;
    logic [HDR_W-1:0]   w_hdr;
    logic               w_ok;
    logic [NUM_CLK-1:0] w_mask;
    logic [NUM_CLK-1:0] n_b_mask;
    logic [CNT_W-1:0]   w_count;

    assign w_c_ready     = !r_c_valid || m_axis_tready;
    assign w_b_ready     = !r_b_valid || w_c_ready;
    assign w_a_ready     = !r_a_valid || w_b_ready;
    assign s_axis_tready = w_a_ready;

    phcs_fec_decode u_fec (
        .i_coded  (r_a_coded),
        .o_header (w_hdr),
        .o_fec_ok (w_ok)
    );

    for (genvar c = 0; c < NUM_CLK; c++) begin : g_trial
        phcs_clock_trial u_trial (
            .i_header  (w_hdr),
            .i_uap     (r_a_uap),
            .i_clk_val (CLK_W'(c)),
            .o_match   (w_mask[c])
        );
    end

    assign n_b_mask = w_ok ? w_mask : '0;

    phcs_popcount u_pop (
        .i_mask  (r_b_mask),
        .o_count (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= s_axis_tvalid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (w_c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && s_axis_tvalid) begin
            r_a_coded <= s_axis_tdata[CODED_W-1:0];
            r_a_uap   <= s_axis_tdata[CODED_W+UAP_W-1:CODED_W];
        end
        if (w_b_ready && r_a_valid) begin
            r_b_hdr  <= w_hdr;
            r_b_ok   <= w_ok;
            r_b_mask <= n_b_mask;
        end
        if (w_c_ready && r_b_valid) begin
            r_c_hdr   <= r_b_hdr;
            r_c_ok    <= r_b_ok;
            r_c_mask  <= r_b_mask;
            r_c_count <= w_count;
        end
    end

    assign m_axis_tvalid = r_c_valid;
    assign m_axis_tdata  = {6'b000000, r_c_count, r_c_mask, r_c_ok, r_c_hdr};

    a_count_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> (r_c_count == CNT_W'($countones(r_c_mask))))
        else $error("match count disagrees with mask");

    a_fec_fail_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !r_b_ok) |-> (r_b_mask == '0))
        else $error("mask set although FEC check failed");

    a_result_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && !m_axis_tready) |=> (r_c_valid && $stable(r_c_mask)
                                          && $stable(r_c_hdr)))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_a_valid || !r_b_valid || !r_c_valid) |-> s_axis_tready)
        else $error("input stalled with a free stage");

endmodule

// ===== hdl/phcs_fec_decode.sv =====
// Majority decoder for the 18 rate-1/3 repetition triples of the header.
// Depends on phcs_pkg for the widths.
module phcs_fec_decode
    import phcs_pkg::*;
(
    input  logic [CODED_W-1:0] i_coded,
    output logic [HDR_W-1:0]   o_header,
    output logic               o_fec_ok
);

    logic [HDR_W-1:0] w_unan;

    always_comb begin
        for (int t = 0; t < HDR_W; t++) begin
            o_header[t] = (i_coded[3*t] & i_coded[3*t+1]) |
                          (i_coded[3*t] & i_coded[3*t+2]) |
                          (i_coded[3*t+1] & i_coded[3*t+2]);
            w_unan[t]   = (i_coded[3*t] == i_coded[3*t+1]) &&
                          (i_coded[3*t] == i_coded[3*t+2]);
        end
    end

    assign o_fec_ok = &w_unan;

endmodule

// ===== hdl/phcs_clock_trial.sv =====
// One clock trial: dewhitens the header for a clock value and checks its HEC.
// Depends on phcs_pkg for whiten_seq and hec_calc.
module phcs_clock_trial
    import phcs_pkg::*;
(
    input  logic [HDR_W-1:0] i_header,
    input  logic [UAP_W-1:0] i_uap,
    input  logic [CLK_W-1:0] i_clk_val,
    output logic             o_match
);

    logic [HDR_W-1:0] w_dw;
    logic [HEC_W-1:0] w_hec;
    logic [HEC_W-1:0] w_rev;

    assign w_dw  = i_header ^ whiten_seq(i_clk_val);
    assign w_hec = hec_calc(w_dw[DATA_W-1:0], i_uap);

    // The HEC goes on air MSB first, so the received bits are reversed.
    always_comb begin
        for (int k = 0; k < HEC_W; k++) begin
            w_rev[k] = w_hec[HEC_W-1-k];
        end
    end

    assign o_match = (w_dw[HDR_W-1:DATA_W] == w_rev);

endmodule

// ===== hdl/phcs_popcount.sv =====
// Population count of the 64-bit clock match mask, as byte counts then a sum.
// Depends on phcs_pkg for the widths.
module phcs_popcount
    import phcs_pkg::*;
(
    input  logic [NUM_CLK-1:0] i_mask,
    output logic [CNT_W-1:0]   o_count
);

    logic [3:0] w_part [8];

    always_comb begin
        for (int g = 0; g < 8; g++) begin
            w_part[g] = '0;
            for (int b = 0; b < 8; b++) begin
                w_part[g] = w_part[g] + {3'b000, i_mask[8*g+b]};
            end
        end
        o_count = '0;
        for (int g = 0; g < 8; g++) begin
            o_count = o_count + {3'b000, w_part[g]};
        end
    end

endmodule
